/* rtl/lcb_pkg.sv */
// lcb_pkg: shared types, constants and digit helpers for the Luhn card brand check
// used by lcb_cell, lcb_scan, luhn_card_brand_check and lcb_checker; no dependencies
package lcb_pkg;

    // field and bus widths
    localparam int IN_W         = 63;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 16;
    localparam int DIGIT_W      = 4;
    localparam int CNT_W        = 5;
    localparam int PAIR_W       = 7;
    localparam int BRAND_W      = 2;

    // conversion geometry: 63 input bits hold at most 19 decimal digits
    localparam int NUM_CELLS     = 19;
    localparam int BITS_PER_STEP = 7;
    localparam int CONV_STEPS    = IN_W / BITS_PER_STEP;

    // brand codes
    localparam logic [BRAND_W-1:0] BRAND_NONE  = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_3X    = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_5X    = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_4X    = 2'd3;

    // prefixes and lengths of the brand rules
    localparam logic [PAIR_W-1:0] PFX_3X_A     = 7'd34;
    localparam logic [PAIR_W-1:0] PFX_3X_B     = 7'd37;
    localparam logic [PAIR_W-1:0] PFX_5X_LO    = 7'd51;
    localparam logic [PAIR_W-1:0] PFX_5X_HI    = 7'd55;
    localparam logic [PAIR_W-1:0] PFX_4X_LO    = 7'd40;
    localparam logic [PAIR_W-1:0] PFX_4X_HI    = 7'd49;
    localparam logic [CNT_W-1:0]  LEN_SHORT    = 5'd13;
    localparam logic [CNT_W-1:0]  LEN_3X       = 5'd15;
    localparam logic [CNT_W-1:0]  LEN_LONG     = 5'd16;

    typedef logic [DIGIT_W-1:0] digit_t;

    // operation of one digit cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONV,
        CELL_SHIFT
    } cell_op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the digit scanner
    typedef struct packed {
        logic              clear;
        logic              step;
        logic [CNT_W-1:0]  index;
    } scan_ctrl_t;

    // add-3 correction of a bcd digit before it is shifted left
    function automatic digit_t dd_adjust(input digit_t d);
        digit_t r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

    // luhn weight of one digit: doubled digits fold their two decimal digits
    function automatic digit_t luhn_fold(input digit_t d, input logic dbl);
        logic [DIGIT_W:0] twice;
        digit_t           r;
        twice = {d, 1'b0};
        if (!dbl)
        begin
            r = d;
        end
        else if (twice > 5'd9)
        begin
            twice = twice - 5'd9;
            r = twice[DIGIT_W-1:0];
        end
        else
        begin
            r = twice[DIGIT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lcb_cell.sv */
// lcb_cell: one bcd digit cell of the binary to decimal converter row
// depends on lcb_pkg; converts several input bits per cycle, then shifts its digit down
module lcb_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcb_pkg::cell_op_t                   op,
    input  logic [lcb_pkg::BITS_PER_STEP-1:0]   carry_in,   // bit s enters at step s
    output logic [lcb_pkg::BITS_PER_STEP-1:0]   carry_out,  // bit s leaves at step s
    input  lcb_pkg::digit_t                     shift_in,
    output lcb_pkg::digit_t                     digit
);
    import lcb_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t conv_digit;

    // several double-dabble steps on this digit, bits ripple in from the lower cell
    always_comb
    begin
        digit_t d;
        digit_t adj;
        d = digit_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            adj          = dd_adjust(d);
            carry_out[s] = adj[DIGIT_W-1];
            d            = {adj[DIGIT_W-2:0], carry_in[s]};
        end
        conv_digit = d;
    end

    // next digit by operation
    always_comb
    begin
        case (op)
            CELL_HOLD:  digit_next = digit_reg;
            CELL_CLEAR: digit_next = '0;
            CELL_CONV:  digit_next = conv_digit;
            CELL_SHIFT: digit_next = shift_in;
            default:    digit_next = digit_reg;
        endcase
    end

    // digit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

/* rtl/lcb_scan.sv */
// lcb_scan: walks the decimal digits from the least significant end
// depends on lcb_pkg; forms the luhn sum mod 10, digit count, leading pair and brand
module lcb_scan #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lcb_pkg::scan_ctrl_t            ctrl,
    input  lcb_pkg::digit_t                digit,
    output logic [lcb_pkg::BRAND_W-1:0]    card_brand,
    output logic                           luhn_valid,
    output logic [lcb_pkg::CNT_W-1:0]      digit_count,
    output logic [lcb_pkg::PAIR_W-1:0]     leading_pair
);
    import lcb_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] MAX_PAIR_LEN = CNT_W'(MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] MIN_PAIR_LEN = 5'd3;

    digit_t             sum_reg, sum_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    digit_t             prev_reg, prev_next;
    logic [PAIR_W-1:0]  pair_reg, pair_next;

    logic [DIGIT_W:0]   sum_wide;
    logic [PAIR_W-1:0]  pair_cand;
    logic               pair_ok;

    // per-digit update
    always_comb
    begin
        sum_next  = sum_reg;
        top_next  = top_reg;
        prev_next = prev_reg;
        pair_next = pair_reg;
        sum_wide  = {1'b0, sum_reg} + {1'b0, luhn_fold(digit, ctrl.index[0])};
        if (sum_wide >= 5'd10)
        begin
            sum_wide = sum_wide - 5'd10;
        end
        pair_cand = {digit, 3'b000} + {2'b00, digit, 1'b0} + {3'b000, prev_reg};
        if (ctrl.clear)
        begin
            sum_next  = '0;
            top_next  = '0;
            prev_next = '0;
            pair_next = '0;
        end
        else if (ctrl.step)
        begin
            // only the lowest digits up to the limit enter the sum
            if (ctrl.index < MAX_CNT)
            begin
                sum_next = sum_wide[DIGIT_W-1:0];
            end
            // a nonzero digit is the most significant one so far
            if (digit != '0)
            begin
                top_next = ctrl.index + 5'd1;
                if (ctrl.index != '0)
                begin
                    pair_next = pair_cand;
                end
            end
            prev_next = digit;
        end
    end

    // accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            top_reg  <= '0;
            prev_reg <= '0;
            pair_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            top_reg  <= top_next;
            prev_reg <= prev_next;
            pair_reg <= pair_next;
        end
    end

    // results from the accumulated state
    assign luhn_valid   = (sum_reg == '0);
    assign digit_count  = (top_reg > MAX_CNT) ? MAX_CNT : top_reg;
    assign pair_ok      = (top_reg >= MIN_PAIR_LEN) && (top_reg <= MAX_PAIR_LEN);
    assign leading_pair = pair_ok ? pair_reg : '0;

    // brand rules, only for a passing checksum
    always_comb
    begin
        card_brand = BRAND_NONE;
        if (luhn_valid)
        begin
            if ((digit_count == LEN_3X)
                && ((leading_pair == PFX_3X_A) || (leading_pair == PFX_3X_B)))
            begin
                card_brand = BRAND_3X;
            end
            else if ((digit_count == LEN_LONG)
                     && (leading_pair >= PFX_5X_LO) && (leading_pair <= PFX_5X_HI))
            begin
                card_brand = BRAND_5X;
            end
            else if (((digit_count == LEN_SHORT) || (digit_count == LEN_LONG))
                     && (leading_pair >= PFX_4X_LO) && (leading_pair <= PFX_4X_HI))
            begin
                card_brand = BRAND_4X;
            end
        end
    end

endmodule

/* rtl/luhn_card_brand_check.sv */
// luhn_card_brand_check: top level, sequencer, converter cell row and result register
// depends on lcb_pkg, lcb_cell and lcb_scan
//
//   channel  dir  fields (tdata from bit 0 up)
//   s_axis   in   card_number[62:0], bit 63 zero fill
//   m_axis   out  card_brand[1:0], luhn_valid[2], digit_count[7:3], leading_pair[14:8], bit 15 zero
//
// after its input is accepted, an item passes through conversion
// (7 bits per cycle through the row of 19 bcd cells), then the digit scan
// (one digit per cycle out of the low cell), then the load of the result register;
// inputs are taken only in idle, so a new item waits until the last result is loaded.
// s_tready is high only between items; a result waiting on m_tready holds the next
// input off only once that next item has finished its scan.
// reset is asynchronous, active low, and empties the result register.
module luhn_card_brand_check #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcb_pkg::IN_TDATA_W-1:0]      s_tdata,   // card_number[62:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcb_pkg::OUT_TDATA_W-1:0]     m_tdata    // brand, valid, count, pair
);
    import lcb_pkg::*;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IN_W-1:0]            bin_reg, bin_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    cell_op_t                   cell_op;
    scan_ctrl_t                 sctrl;
    logic                       out_load;

    logic [BITS_PER_STEP-1:0]   carry [NUM_CELLS];
    digit_t                     cell_digit [NUM_CELLS];

    logic [BRAND_W-1:0]         card_brand;
    logic                       luhn_valid;
    logic [CNT_W-1:0]           digit_count;
    logic [PAIR_W-1:0]          leading_pair;

    // sequencer next state and controls
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        cell_op    = CELL_HOLD;
        sctrl      = '0;
        out_load   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    bin_next    = s_tdata[IN_W-1:0];
                    cell_op     = CELL_CLEAR;
                    sctrl.clear = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_op  = CELL_CONV;
                bin_next = bin_reg << BITS_PER_STEP;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SCAN:
            begin
                cell_op     = CELL_SHIFT;
                sctrl.step  = 1'b1;
                sctrl.index = cnt_reg;
                if (cnt_reg == CNT_W'(NUM_CELLS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // top input bits feed the low cell, most significant first
    always_comb
    begin
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            carry[0][s] = bin_reg[IN_W-1-s];
        end
    end

    // row of bcd cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        if (i == NUM_CELLS - 1)
        begin : g_top
            lcb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .carry_in  (carry[i]),
                .carry_out (),
                .shift_in  ('0),
                .digit     (cell_digit[i])
            );
        end
        else
        begin : g_mid
            lcb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .shift_in  (cell_digit[i+1]),
                .digit     (cell_digit[i])
            );
        end
    end

    // digit scanner on the low cell
    lcb_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (sctrl),
        .digit        (cell_digit[0]),
        .card_brand   (card_brand),
        .luhn_valid   (luhn_valid),
        .digit_count  (digit_count),
        .leading_pair (leading_pair)
    );

    // result register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, leading_pair, digit_count, luhn_valid, card_brand};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/lcb_checker.sv */
// lcb_checker: port-level assertions for luhn_card_brand_check, bound to the top level
// depends on lcb_pkg and on luhn_card_brand_check
module lcb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [lcb_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import lcb_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted transaction keeps the input closed in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    // a brand is reported only with a passing checksum
    a_brand_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != BRAND_NONE) |-> m_tdata[2])
        else $error("brand without passing checksum");

    // digit count never exceeds what 63 bits can hold
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] <= 5'd19))
        else $error("digit count out of range");

    // first brand only at its length
    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == BRAND_3X) |-> (m_tdata[7:3] == LEN_3X))
        else $error("first brand with wrong length");

endmodule

bind luhn_card_brand_check lcb_checker u_lcb_checker (.*);
